FILE: sv/tct_pkg.sv
// shared types, codes and default sizes for the touch contact tracker
// no dependencies
`timescale 1ns / 1ps

package tct_pkg;

  localparam int SLOT_BITS   = 4;
  localparam int STATE_BITS  = 3;
  localparam int FIELD_XY    = 16;
  localparam int COUNT_BITS  = 4;
  localparam int KIND_BITS   = 2;

  localparam int DEF_NUM_SLOTS           = 10;
  localparam int DEF_CONTACTS_PER_REPORT = 2;
  localparam int DEF_COORD_BITS          = 16;
  localparam int QUEUE_DEPTH             = 2;

  localparam logic [KIND_BITS-1:0] KIND_FINGER   = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_PEN      = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_NO_TOUCH = 2'd2;

  localparam logic [STATE_BITS-1:0] ST_ABSENT        = 3'd0;
  localparam logic [STATE_BITS-1:0] ST_FINGER_ACCUR  = 3'd1;
  localparam logic [STATE_BITS-1:0] ST_FINGER_OTHER  = 3'd2;
  localparam logic [STATE_BITS-1:0] ST_PEN_TIP       = 3'd3;
  localparam logic [STATE_BITS-1:0] ST_PEN_ERASER    = 3'd4;

  typedef enum logic {
    OP_SLOT,
    OP_FRAME
  } tct_op_t;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_PEN,
    ENG_LIFT,
    ENG_FINGER,
    ENG_DROP
  } tct_eng_state_t;

  typedef struct packed {
    logic                  func;
    logic [SLOT_BITS-1:0]  slot;
    logic [STATE_BITS-1:0] contact_state;
    logic [FIELD_XY-1:0]   pos_x;
    logic [FIELD_XY-1:0]   pos_y;
  } tct_in_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]  kind;
    logic [COUNT_BITS-1:0] contact_count;
    logic                  group_start;
    logic [SLOT_BITS-1:0]  contact_id;
    logic [FIELD_XY-1:0]   out_x;
    logic [FIELD_XY-1:0]   out_y;
    logic                  tip;
    logic                  pen_in_range;
    logic                  pen_tip;
    logic                  pen_eraser;
    logic                  last;
  } tct_out_t;

  typedef struct packed {
    tct_op_t               op;
    logic [SLOT_BITS-1:0]  slot;
    logic [STATE_BITS-1:0] contact_state;
    logic [FIELD_XY-1:0]   pos_x;
    logic [FIELD_XY-1:0]   pos_y;
  } tct_cmd_t;

endpackage

FILE: sv/tct_front.sv
// front part: takes requests and classifies them into commands
// depends on tct_pkg
`timescale 1ns / 1ps

module tct_front import tct_pkg::*; #(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  logic     start,
  input  logic     busy,
  input  tct_in_t  item,
  output logic     push,
  output tct_cmd_t cmd
);

  logic slot_ok;

  // out-of-range slots never reach the back part
  assign slot_ok = (32'(item.slot) < NUM_SLOTS);

  always_comb begin
    cmd.op            = item.func ? OP_FRAME : OP_SLOT;
    cmd.slot          = item.slot;
    cmd.contact_state = item.contact_state;
    cmd.pos_x         = item.pos_x;
    cmd.pos_y         = item.pos_y;
    push              = start && !busy && (item.func || slot_ok);
  end

endmodule

FILE: sv/tct_queue.sv
// short command queue between the front and the back part
// depends on tct_pkg
`timescale 1ns / 1ps

module tct_queue import tct_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  tct_cmd_t din,
  input  logic     pop,
  output tct_cmd_t dout,
  output logic     empty,
  output logic     full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  tct_cmd_t        entries [DEPTH];
  logic [AW-1:0]   rd_ptr;
  logic [AW-1:0]   wr_ptr;
  logic [NW-1:0]   fill;

  assign empty = (fill == '0);
  assign full  = (fill == NW'(DEPTH));
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: sv/tct_engine.sv
// back part: slot state, down-order list, frame report walk and list compaction
// depends on tct_pkg
`timescale 1ns / 1ps

module tct_engine import tct_pkg::*; #(
  parameter int NUM_SLOTS           = DEF_NUM_SLOTS,
  parameter int CONTACTS_PER_REPORT = DEF_CONTACTS_PER_REPORT,
  parameter int COORD_BITS          = DEF_COORD_BITS
) (
  input  logic     clk,
  input  logic     rst,
  input  tct_cmd_t cmd,
  input  logic     empty,
  output logic     pop,
  output logic     strobe,
  output tct_out_t result
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int KW = $clog2(CONTACTS_PER_REPORT + 1);

  tct_eng_state_t state, state_next;

  logic [NUM_SLOTS-1:0]  valid_mask, valid_mask_next;
  logic [NUM_SLOTS-1:0]  lift_pending, lift_pending_next;
  logic [NUM_SLOTS-1:0]  removed, removed_next;
  logic [CW-1:0]         down_count, down_count_next;
  logic [CW-1:0]         done_idx, done_idx_next;
  logic [CW-1:0]         rd_j, rd_j_next;
  logic [CW-1:0]         wr_w, wr_w_next;
  logic [KW-1:0]         k, k_next;
  logic                  has_pen, has_pen_next;
  logic                  pen_was_present, pen_was_present_next;

  logic [SLOT_BITS-1:0]  down_order  [NUM_SLOTS];
  logic [STATE_BITS-1:0] slot_status [NUM_SLOTS];
  logic [COORD_BITS-1:0] slot_x      [NUM_SLOTS];
  logic [COORD_BITS-1:0] slot_y      [NUM_SLOTS];

  logic                  list_we;
  logic [IW-1:0]         list_waddr;
  logic [SLOT_BITS-1:0]  list_wdata;
  logic                  stat_we;
  logic                  pos_we;
  logic [IW-1:0]         cmd_idx;

  tct_out_t              result_next;
  logic                  strobe_next;

  logic [CW-1:0]         rem;
  logic [KW-1:0]         gsize;
  logic [CW-1:0]         rd_sum;
  logic [SLOT_BITS-1:0]  cur_slot;
  logic [STATE_BITS-1:0] cur_st;
  logic                  cur_pen;
  logic                  k_end;
  logic                  frame_end;
  logic [SLOT_BITS-1:0]  drop_v;
  logic                  drop_hit;
  logic                  cmd_valid;
  logic                  cmd_append;

  assign cmd_idx  = cmd.slot[IW-1:0];
  assign rem      = down_count - done_idx;
  assign gsize    = (32'(rem) > CONTACTS_PER_REPORT) ? KW'(CONTACTS_PER_REPORT) : KW'(rem);
  assign rd_sum   = (state == ENG_DROP) ? rd_j : done_idx + CW'(k);
  assign cur_slot = down_order[rd_sum[IW-1:0]];
  assign cur_st   = slot_status[cur_slot[IW-1:0]];
  assign cur_pen  = cur_st inside {ST_PEN_TIP, ST_PEN_ERASER};
  assign k_end    = (k == gsize - 1'b1);
  assign frame_end = (32'(done_idx) + 32'(gsize)) >= 32'(down_count);
  assign drop_v   = cur_slot;
  assign drop_hit = lift_pending[drop_v[IW-1:0]] && !removed[drop_v[IW-1:0]];

  assign cmd_append = (cmd.contact_state != ST_ABSENT) && !valid_mask[cmd_idx]
                      && (32'(down_count) < NUM_SLOTS);
  assign cmd_valid  = valid_mask[cmd_idx] || cmd_append;

  always_comb begin
    state_next           = state;
    valid_mask_next      = valid_mask;
    lift_pending_next    = lift_pending;
    removed_next         = removed;
    down_count_next      = down_count;
    done_idx_next        = done_idx;
    rd_j_next            = rd_j;
    wr_w_next            = wr_w;
    k_next               = k;
    has_pen_next         = has_pen;
    pen_was_present_next = pen_was_present;
    pop                  = 1'b0;
    list_we              = 1'b0;
    list_waddr           = down_count[IW-1:0];
    list_wdata           = cmd.slot;
    stat_we              = 1'b0;
    pos_we               = 1'b0;
    strobe_next          = 1'b0;
    result_next          = '0;

    case (state)
      ENG_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          if (cmd.op == OP_SLOT) begin
            if (cmd_append) begin
              list_we         = 1'b1;
              down_count_next = down_count + 1'b1;
            end
            if (cmd_valid) begin
              stat_we = 1'b1;
              if (cmd.contact_state != ST_ABSENT) begin
                pos_we                   = 1'b1;
                valid_mask_next[cmd_idx] = 1'b1;
              end else begin
                lift_pending_next[cmd_idx] = 1'b1;
                valid_mask_next[cmd_idx]   = 1'b0;
              end
            end
          end else if (down_count == '0) begin
            strobe_next      = 1'b1;
            result_next.kind = KIND_NO_TOUCH;
            result_next.last = 1'b1;
            rd_j_next        = '0;
            wr_w_next        = '0;
            removed_next     = '0;
            state_next       = ENG_DROP;
          end else begin
            done_idx_next = '0;
            k_next        = '0;
            has_pen_next  = 1'b0;
            state_next    = ENG_PEN;
          end
        end
      end

      ENG_PEN: begin
        if (cur_pen) begin
          strobe_next              = 1'b1;
          result_next.kind         = KIND_PEN;
          result_next.contact_id   = cur_slot;
          result_next.out_x        = FIELD_XY'(slot_x[cur_slot[IW-1:0]]);
          result_next.out_y        = FIELD_XY'(slot_y[cur_slot[IW-1:0]]);
          result_next.pen_in_range = 1'b1;
          result_next.pen_tip      = 1'b1;
          result_next.pen_eraser   = (cur_st == ST_PEN_ERASER);
          has_pen_next             = 1'b1;
          pen_was_present_next     = 1'b1;
        end
        if (k_end) begin
          k_next     = '0;
          state_next = ENG_LIFT;
        end else begin
          k_next = k + 1'b1;
        end
      end

      ENG_LIFT: begin
        if (!has_pen && pen_was_present) begin
          strobe_next          = 1'b1;
          result_next.kind     = KIND_PEN;
          pen_was_present_next = 1'b0;
        end
        state_next = ENG_FINGER;
      end

      ENG_FINGER: begin
        strobe_next               = 1'b1;
        result_next.kind          = KIND_FINGER;
        result_next.contact_count = (done_idx == '0) ? COUNT_BITS'(down_count) : '0;
        result_next.group_start   = (k == '0);
        result_next.contact_id    = cur_slot;
        if (cur_st == ST_FINGER_ACCUR) begin
          result_next.out_x = FIELD_XY'(slot_x[cur_slot[IW-1:0]]);
          result_next.out_y = FIELD_XY'(slot_y[cur_slot[IW-1:0]]);
          result_next.tip   = 1'b1;
        end
        result_next.last = k_end && frame_end;
        if (k_end) begin
          k_next        = '0;
          has_pen_next  = 1'b0;
          done_idx_next = done_idx + CW'(gsize);
          if (frame_end) begin
            rd_j_next    = '0;
            wr_w_next    = '0;
            removed_next = '0;
            state_next   = ENG_DROP;
          end else begin
            state_next = ENG_PEN;
          end
        end else begin
          k_next = k + 1'b1;
        end
      end

      ENG_DROP: begin
        if (down_count == '0) begin
          lift_pending_next = '0;
          state_next        = ENG_IDLE;
        end else begin
          // first occurrence of a lifted slot is removed, the rest move up
          if (drop_hit) begin
            removed_next[drop_v[IW-1:0]] = 1'b1;
          end else begin
            list_we    = 1'b1;
            list_waddr = wr_w[IW-1:0];
            list_wdata = drop_v;
            wr_w_next  = wr_w + 1'b1;
          end
          if (rd_j == down_count - 1'b1) begin
            down_count_next   = wr_w_next;
            lift_pending_next = '0;
            state_next        = ENG_IDLE;
          end else begin
            rd_j_next = rd_j + 1'b1;
          end
        end
      end

      default: begin
        state_next = ENG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (list_we) begin
      down_order[list_waddr] <= list_wdata;
    end
    if (stat_we) begin
      slot_status[cmd_idx] <= cmd.contact_state;
    end
    if (pos_we) begin
      slot_x[cmd_idx] <= cmd.pos_x[COORD_BITS-1:0];
      slot_y[cmd_idx] <= cmd.pos_y[COORD_BITS-1:0];
    end
    result   <= result_next;
    removed  <= removed_next;
    done_idx <= done_idx_next;
    rd_j     <= rd_j_next;
    wr_w     <= wr_w_next;
    k        <= k_next;
    has_pen  <= has_pen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ENG_IDLE;
      valid_mask      <= '0;
      lift_pending    <= '0;
      down_count      <= '0;
      pen_was_present <= 1'b0;
      strobe          <= 1'b0;
    end else begin
      state           <= state_next;
      valid_mask      <= valid_mask_next;
      lift_pending    <= lift_pending_next;
      down_count      <= down_count_next;
      pen_was_present <= pen_was_present_next;
      strobe          <= strobe_next;
    end
  end

endmodule

FILE: sv/touch_contact_tracker.sv
// top level of the touch contact tracker: front part, command queue, back part
// depends on tct_pkg, tct_front, tct_queue, tct_engine
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; busy rises only while
// the two-entry command queue is full. The back part handles a slot request in
// its idle state. An end-of-frame request walks the listed contacts in groups of
// CONTACTS_PER_REPORT (pen pass, pen-lift check and finger pass per group), then
// compacts the list entry by entry; an empty list gives a single no-touch result.
// Results leave at most one per cycle, during the pen, pen-lift and finger passes
// or as the no-touch result, each on result for exactly one cycle with strobe
// high, and last marks the final one of the frame. The receiver cannot stall the
// block, so results must be taken as they appear.
module touch_contact_tracker import tct_pkg::*; #(
  parameter int NUM_SLOTS           = DEF_NUM_SLOTS,
  parameter int CONTACTS_PER_REPORT = DEF_CONTACTS_PER_REPORT,
  parameter int COORD_BITS          = DEF_COORD_BITS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  tct_in_t  item,
  output logic     strobe,
  output tct_out_t result
);

  logic     push;
  logic     pop;
  logic     empty;
  logic     full;
  tct_cmd_t cmd_in;
  tct_cmd_t cmd_out;

  assign busy = full;

  tct_front #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_front (
    .start (start),
    .busy  (busy),
    .item  (item),
    .push  (push),
    .cmd   (cmd_in)
  );

  tct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cmd_in),
    .pop   (pop),
    .dout  (cmd_out),
    .empty (empty),
    .full  (full)
  );

  tct_engine #(
    .NUM_SLOTS           (NUM_SLOTS),
    .CONTACTS_PER_REPORT (CONTACTS_PER_REPORT),
    .COORD_BITS          (COORD_BITS)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_out),
    .empty  (empty),
    .pop    (pop),
    .strobe (strobe),
    .result (result)
  );

endmodule
